// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker of this block.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/amt_pkg.sv =====
// Shared types, codes and defaults for the multi-channel alarm timer.
// Used by the interfaces, the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package amt_pkg;

   localparam int NUM_CHANNELS_DEF = 32;
   localparam int COUNT_WIDTH_DEF  = 16;

   localparam int OP_W     = 2;
   localparam int RELOAD_W = 16;
   localparam int CHAN_W   = 8;
   localparam int STATUS_W = 3;
   localparam int MASK_W   = 32;
   localparam int TOTAL_W  = 6;

   localparam logic [CHAN_W-1:0] NO_HANDLE = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 2'd0,
      OP_ACTIVATE   = 2'd1,
      OP_DEACTIVATE = 2'd2,
      OP_POLL       = 2'd3
   } amt_op_type;

   localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COUNTING   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RINGING    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOFREE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE       = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;      // capture the request beat, rewind the channel index
      logic idx_inc;     // step the channel index
      logic walk_issue;  // read both stores at the channel index
      logic commit;      // apply the operation and load the result register
   } amt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy_full;   // busy total has reached the channel count
      logic scan_hit;    // channel at the index is neither enabled nor ringing
      logic idx_last;    // index points at the last channel
   } amt_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/amt_if.sv =====
// Valid/ready channel interfaces for requests and responses of the alarm timer.
// Depends on amt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface amt_req_if;
   logic                          valid;
   logic                          ready;
   logic [amt_pkg::OP_W-1:0]      operation;
   logic [amt_pkg::RELOAD_W-1:0]  reload_value;
   logic                          periodic;
   logic [amt_pkg::CHAN_W-1:0]    channel;

   modport source (output valid, operation, reload_value, periodic, channel, input ready);
   modport sink   (input valid, operation, reload_value, periodic, channel, output ready);
   modport monitor (input valid, ready, operation, reload_value, periodic, channel);
endinterface

interface amt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [amt_pkg::CHAN_W-1:0]    handle;
   logic [amt_pkg::STATUS_W-1:0]  status;
   logic [amt_pkg::MASK_W-1:0]    ring_mask;
   logic [amt_pkg::TOTAL_W-1:0]   enabled_count;
   logic [amt_pkg::TOTAL_W-1:0]   busy_count;

   modport source (output valid, handle, status, ring_mask, enabled_count, busy_count,
                   input ready);
   modport sink   (input valid, handle, status, ring_mask, enabled_count, busy_count,
                   output ready);
   modport monitor (input valid, ready, handle, status, ring_mask, enabled_count,
                    busy_count);
endinterface

`default_nettype wire

// ===== rtl/core/multi_channel_alarm_timer.sv =====
// Top level of the multi-channel alarm timer: controller plus datapath.
// Depends on amt_pkg, amt_if, amt_ctrl and amt_dp.
`timescale 1ns / 1ps
`default_nettype none

// One request beat is taken at a time and yields exactly one response beat.
// A tick reads every channel's reload and counter through one read port of
// the stores, one channel per cycle, then passes the drain and done states
// before the next accept. Activate scans the flags one channel per cycle for
// the lowest free one, or goes straight to the done state when every channel
// is counted busy. Deactivate and poll go from accept straight to done.
// The response sits in a register, so a new request is taken while the last
// response still waits; only the end of the next operation waits for it.
// Reload and counter stores need no clearing after reset.
module multi_channel_alarm_timer #(
   parameter int NUM_CHANNELS = amt_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = amt_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   amt_req_if.sink    req_bus,
   amt_rsp_if.source  rsp_bus
);

   amt_pkg::amt_cmd_type  cmd;
   amt_pkg::amt_stat_type stat;

   amt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.operation),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   amt_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_bus.operation),
      .req_reload        (req_bus.reload_value),
      .req_periodic      (req_bus.periodic),
      .req_channel       (req_bus.channel),
      .rsp_handle        (rsp_bus.handle),
      .rsp_status        (rsp_bus.status),
      .rsp_ring_mask     (rsp_bus.ring_mask),
      .rsp_enabled_count (rsp_bus.enabled_count),
      .rsp_busy_count    (rsp_bus.busy_count)
   );

endmodule

`default_nettype wire

// ===== rtl/core/amt_ctrl.sv =====
// Controller of the alarm timer: sequences accept, tick walk, free-channel scan
// and result hand-off. Depends on amt_pkg for command and status types.
`timescale 1ns / 1ps
`default_nettype none

module amt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic [amt_pkg::OP_W-1:0]  req_op,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire amt_pkg::amt_stat_type     stat,
   output amt_pkg::amt_cmd_type           cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WALK  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      out_vld_ff, out_vld_in;
   logic      out_free;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = out_vld_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               case (amt_pkg::amt_op_type'(req_op))
                  amt_pkg::OP_TICK:     state_in = S_WALK;
                  amt_pkg::OP_ACTIVATE: state_in = stat.busy_full ? S_DONE : S_SCAN;
                  default:              state_in = S_DONE;
               endcase
            end
         end
         S_WALK: begin
            cmd.walk_issue = 1'b1;
            if (stat.idx_last) begin
               state_in = S_DRAIN;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         // The last channel read is processed here before the result is formed.
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (stat.scan_hit || stat.idx_last) begin
               state_in = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.commit) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/amt_dp.sv =====
// Datapath of the alarm timer: channel flags, reload and counter stores, totals,
// tick walk stage and result register. Depends on amt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amt_dp #(
   parameter int NUM_CHANNELS = amt_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = amt_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire amt_pkg::amt_cmd_type           cmd,
   output amt_pkg::amt_stat_type               stat,
   input  wire logic [amt_pkg::OP_W-1:0]       req_op,
   input  wire logic [amt_pkg::RELOAD_W-1:0]   req_reload,
   input  wire logic                           req_periodic,
   input  wire logic [amt_pkg::CHAN_W-1:0]     req_channel,
   output logic [amt_pkg::CHAN_W-1:0]          rsp_handle,
   output logic [amt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [amt_pkg::MASK_W-1:0]          rsp_ring_mask,
   output logic [amt_pkg::TOTAL_W-1:0]         rsp_enabled_count,
   output logic [amt_pkg::TOTAL_W-1:0]         rsp_busy_count
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int TOT_W = $clog2(NUM_CHANNELS + 1);

   // Request beat held for the duration of the operation.
   amt_pkg::amt_op_type                op_ff;
   logic [amt_pkg::RELOAD_W-1:0]       reload_ff;
   logic                               per_ff;
   logic [amt_pkg::CHAN_W-1:0]         ch_ff;

   logic [NUM_CHANNELS-1:0]  enable_ff, enable_in;
   logic [NUM_CHANNELS-1:0]  ring_ff, ring_in;
   logic [NUM_CHANNELS-1:0]  period_ff, period_in;
   logic [TOT_W-1:0]         en_tot_ff, en_tot_in;
   logic [TOT_W-1:0]         busy_ff, busy_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;

   // Walk stage: registered store reads for one channel.
   logic                     stg_vld_ff;
   logic [IDX_W-1:0]         stg_idx_ff;
   logic [COUNT_WIDTH-1:0]   rd_rel_ff;
   logic [COUNT_WIDTH-1:0]   rd_cnt_ff;

   logic [COUNT_WIDTH-1:0]   rel_mem [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]   cnt_mem [NUM_CHANNELS];

   logic                     cnt_we;
   logic [IDX_W-1:0]         cnt_wa;
   logic [COUNT_WIDTH-1:0]   cnt_wd;
   logic                     rel_we;
   logic [COUNT_WIDTH-1:0]   rel_w;

   logic [amt_pkg::CHAN_W-1:0]   res_handle;
   logic [amt_pkg::STATUS_W-1:0] res_status;

   logic [amt_pkg::CHAN_W-1:0]   handle_ff;
   logic [amt_pkg::STATUS_W-1:0] status_ff;
   logic [amt_pkg::MASK_W-1:0]   ring_out_ff;
   logic [amt_pkg::TOTAL_W-1:0]  en_out_ff;
   logic [amt_pkg::TOTAL_W-1:0]  busy_out_ff;

   logic [COUNT_WIDTH+amt_pkg::RELOAD_W-1:0]  rel_ext;
   logic [IDX_W+amt_pkg::CHAN_W-1:0]          idx_ext;
   logic [NUM_CHANNELS+amt_pkg::MASK_W-1:0]   ring_ext;
   logic [TOT_W+amt_pkg::TOTAL_W-1:0]         en_ext;
   logic [TOT_W+amt_pkg::TOTAL_W-1:0]         busy_ext;

   logic [NUM_CHANNELS-1:0]  free_bits;
   logic [IDX_W-1:0]         chi;
   logic                     ch_ok;
   logic                     act_ok;

   assign free_bits = ~(enable_ff | ring_ff);
   assign chi       = ch_ff[IDX_W-1:0];
   assign ch_ok     = (ch_ff < amt_pkg::CHAN_W'(NUM_CHANNELS));

   assign stat.busy_full = (busy_ff >= TOT_W'(NUM_CHANNELS));
   assign stat.scan_hit  = free_bits[idx_ff];
   assign stat.idx_last  = (idx_ff == IDX_W'(NUM_CHANNELS - 1));
   assign act_ok         = !stat.busy_full && free_bits[idx_ff];

   assign rel_ext = {{COUNT_WIDTH{1'b0}}, reload_ff};
   assign rel_w   = rel_ext[COUNT_WIDTH-1:0];
   assign idx_ext = {{amt_pkg::CHAN_W{1'b0}}, idx_ff};

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      enable_in  = enable_ff;
      ring_in    = ring_ff;
      period_in  = period_ff;
      en_tot_in  = en_tot_ff;
      busy_in    = busy_ff;
      cnt_we     = 1'b0;
      cnt_wa     = stg_idx_ff;
      cnt_wd     = '0;
      rel_we     = 1'b0;
      res_handle = amt_pkg::NO_HANDLE;
      res_status = amt_pkg::ST_DONE;

      // Tick walk: one enabled channel advanced, rung or restarted per cycle.
      if (stg_vld_ff && enable_ff[stg_idx_ff]) begin
         if (rd_cnt_ff < rd_rel_ff) begin
            cnt_we = 1'b1;
            cnt_wd = rd_cnt_ff + COUNT_WIDTH'(1);
         end else begin
            ring_in[stg_idx_ff] = 1'b1;
            if (period_ff[stg_idx_ff]) begin
               cnt_we = 1'b1;
            end else begin
               enable_in[stg_idx_ff] = 1'b0;
               if (en_tot_ff != '0) begin
                  en_tot_in = en_tot_ff - TOT_W'(1);
               end
            end
         end
      end

      case (op_ff)
         amt_pkg::OP_ACTIVATE: begin
            if (act_ok) begin
               res_handle = idx_ext[amt_pkg::CHAN_W-1:0];
               res_status = amt_pkg::ST_COUNTING;
               if (cmd.commit) begin
                  rel_we            = 1'b1;
                  cnt_we            = 1'b1;
                  cnt_wa            = idx_ff;
                  enable_in[idx_ff] = 1'b1;
                  period_in[idx_ff] = per_ff;
                  en_tot_in         = en_tot_ff + TOT_W'(1);
                  busy_in           = busy_ff + TOT_W'(1);
               end
            end else begin
               res_status = amt_pkg::ST_NOFREE;
            end
         end
         amt_pkg::OP_DEACTIVATE: begin
            if (!ch_ok) begin
               res_status = amt_pkg::ST_UNASSIGNED;
            end else if (cmd.commit) begin
               if (enable_ff[chi]) begin
                  enable_in[chi] = 1'b0;
                  if (en_tot_ff != '0) begin
                     en_tot_in = en_tot_ff - TOT_W'(1);
                  end
               end
               ring_in[chi] = 1'b0;
               if (busy_ff != '0) begin
                  busy_in = busy_ff - TOT_W'(1);
               end
            end
         end
         amt_pkg::OP_POLL: begin
            res_handle = ch_ff;
            if (!ch_ok) begin
               res_status = amt_pkg::ST_UNASSIGNED;
            end else if (ring_ff[chi]) begin
               res_status = amt_pkg::ST_RINGING;
               if (!period_ff[chi]) begin
                  res_handle = amt_pkg::NO_HANDLE;
               end
               if (cmd.commit) begin
                  ring_in[chi] = 1'b0;
                  if (!period_ff[chi] && busy_ff != '0) begin
                     busy_in = busy_ff - TOT_W'(1);
                  end
               end
            end else begin
               res_status = amt_pkg::ST_COUNTING;
            end
         end
         default: begin
         end
      endcase
   end

   assign ring_ext = {{amt_pkg::MASK_W{1'b0}}, ring_in};
   assign en_ext   = {{amt_pkg::TOTAL_W{1'b0}}, en_tot_in};
   assign busy_ext = {{amt_pkg::TOTAL_W{1'b0}}, busy_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         ring_ff    <= '0;
         period_ff  <= '0;
         en_tot_ff  <= '0;
         busy_ff    <= '0;
         idx_ff     <= '0;
         stg_vld_ff <= 1'b0;
      end else begin
         enable_ff  <= enable_in;
         ring_ff    <= ring_in;
         period_ff  <= period_in;
         en_tot_ff  <= en_tot_in;
         busy_ff    <= busy_in;
         idx_ff     <= idx_in;
         stg_vld_ff <= cmd.walk_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= amt_pkg::amt_op_type'(req_op);
         reload_ff <= req_reload;
         per_ff    <= req_periodic;
         ch_ff     <= req_channel;
      end
      stg_idx_ff <= idx_ff;
      if (cmd.commit) begin
         handle_ff   <= res_handle;
         status_ff   <= res_status;
         ring_out_ff <= ring_ext[amt_pkg::MASK_W-1:0];
         en_out_ff   <= en_ext[amt_pkg::TOTAL_W-1:0];
         busy_out_ff <= busy_ext[amt_pkg::TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (rel_we) begin
         rel_mem[idx_ff] <= rel_w;
      end
      if (cmd.walk_issue) begin
         rd_cnt_ff <= cnt_mem[idx_ff];
         rd_rel_ff <= rel_mem[idx_ff];
      end
   end

   assign rsp_handle        = handle_ff;
   assign rsp_status        = status_ff;
   assign rsp_ring_mask     = ring_out_ff;
   assign rsp_enabled_count = en_out_ff;
   assign rsp_busy_count    = busy_out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/amt_checker.sv =====
// Port-level checks for the alarm timer, bound to the top level.
// Depends on amt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module amt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [amt_pkg::CHAN_W-1:0]    rsp_handle,
   input wire logic [amt_pkg::STATUS_W-1:0]  rsp_status
);

   logic                                          req_take;
   logic                                          rsp_stall;
   logic [amt_pkg::CHAN_W+amt_pkg::STATUS_W-1:0]  rsp_word;
   logic                                          rsp_nofree;
   logic                                          rsp_done;
   logic                                          handle_none;

   assign req_take    = req_valid && req_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_handle, rsp_status};
   assign rsp_nofree  = rsp_valid && (rsp_status == amt_pkg::ST_NOFREE);
   assign rsp_done    = rsp_valid && (rsp_status == amt_pkg::ST_DONE);
   assign handle_none = (rsp_handle == amt_pkg::NO_HANDLE);

   // A stalled response beat keeps its handle and status.
   `AMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // A failed activate never reports a channel.
   `AMT_ASSERT_IMPL(a_nofree_handle, clock, reset, rsp_nofree, handle_none)

   // Tick and deactivate finish without a handle.
   `AMT_ASSERT_IMPL(a_done_handle, clock, reset, rsp_done, handle_none)

   // Operations run one at a time, so an accepted beat closes the request side.
   `AMT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_take, !req_ready)

endmodule

bind multi_channel_alarm_timer amt_checker u_amt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_handle (rsp_bus.handle),
   .rsp_status (rsp_bus.status)
);

`default_nettype wire
